// File: hw/rtl/lkv_pkg.sv
package lkv_pkg;

  typedef logic [31:0] value_t;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  localparam logic [4:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_t;

  // per-cell shift control
  typedef struct packed {
    logic upd;
    logic [7:0] tgt;
  } cell_ctl_t;

endpackage

// File: hw/rtl/lru_key_value_cache.sv
// channel | ports                                                    | direction
// in      | in_valid, in_stall, in_operation, in_key, in_write_value | in
// out     | out_valid, out_stall, out_hit, out_read_value            | out
// cfg     | cfg_we, cfg_wdata                                        | in
//
// Each transfer has a compare state across all cells, then a shift state.
// Entries are kept in recency order along the cell chain, cell 0 most recent.
// A get waits in the compare cycle while its output register is still held.
// rst_n clears valid bits, the fill count and capacity (16); no clearing pass.
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_write_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic signed [31:0] out_read_value,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata
);

  localparam int KB    = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EW    = (CNT_W > 5) ? CNT_W : 5;

  state_t           state_r, state_nxt;
  logic             op_r;
  logic [KB-1:0]    key_r;
  value_t           wval_r;
  logic             hit_r;
  value_t           hval_r;
  logic [IDX_W-1:0] tgt_r;
  logic             ins_r;
  logic [CNT_W-1:0] cnt_r;
  logic [4:0]       cap_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r;
  value_t           out_val_r;

  logic [KB-1:0]    cell_key   [CAPACITY];
  value_t           cell_val   [CAPACITY];
  logic             cell_valid [CAPACITY];
  logic [CAPACITY-1:0] match;

  logic             in_xfer;
  logic             look;
  logic             cell_upd;
  logic             out_load;
  cell_ctl_t        ctl;
  logic             hit_c;
  value_t           hval_c;
  logic [IDX_W-1:0] hidx_c;
  logic [EW-1:0]    cap_ext, eff_cap;
  logic             evict;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] tgt_c;
  logic             ins_c;
  value_t           head_val;

  assign in_xfer = in_valid && !in_stall;

  // lookup across the chain
  always_comb begin
    hit_c  = 1'b0;
    hval_c = '0;
    hidx_c = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        hit_c  = 1'b1;
        hval_c = hval_c | cell_val[i];
        hidx_c = hidx_c | IDX_W'(i);
      end
    end
  end

  always_comb begin
    cap_ext = EW'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(CAPACITY)) begin
      eff_cap = EW'(CAPACITY);
    end else begin
      eff_cap = cap_ext;
    end
    evict  = (EW'(cnt_r) >= eff_cap) || (cnt_r == CNT_W'(CAPACITY));
    cnt_m1 = cnt_r - CNT_W'(1);
    if (hit_c) begin
      tgt_c = hidx_c;
    end else if (evict) begin
      tgt_c = cnt_m1[IDX_W-1:0];
    end else begin
      tgt_c = cnt_r[IDX_W-1:0];
    end
    ins_c = (op_r == OP_SET) && !hit_c && !evict;
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    look      = 1'b0;
    cell_upd  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        look = 1'b1;
        if (!((op_r == OP_GET) && out_valid_r && out_stall)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        in_stall = 1'b0;
        cell_upd = hit_r || (op_r == OP_SET);
        out_load = (op_r == OP_GET);
        state_nxt = in_valid ? S_LOOK : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  assign ctl.upd  = cell_upd;
  assign ctl.tgt  = 8'(tgt_r);
  assign head_val = (op_r == OP_GET) ? hval_r : wval_r;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      lkv_cell #(.KB(KB), .IDX_W(IDX_W), .IDX(g)) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_i        (key_r),
        .ctl_i        (ctl),
        .prev_key_i   (key_r),
        .prev_val_i   (head_val),
        .prev_valid_i (1'b1),
        .key_o        (cell_key[g]),
        .val_o        (cell_val[g]),
        .valid_o      (cell_valid[g]),
        .match_o      (match[g])
      );
    end else begin : g_body
      lkv_cell #(.KB(KB), .IDX_W(IDX_W), .IDX(g)) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_i        (key_r),
        .ctl_i        (ctl),
        .prev_key_i   (cell_key[g-1]),
        .prev_val_i   (cell_val[g-1]),
        .prev_valid_i (cell_valid[g-1]),
        .key_o        (cell_key[g]),
        .val_o        (cell_val[g]),
        .valid_o      (cell_valid[g]),
        .match_o      (match[g])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cell_upd && ins_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= in_operation;
      key_r  <= in_key[KB-1:0];
      wval_r <= in_write_value;
    end
    if (look) begin
      hit_r  <= hit_c;
      hval_r <= hval_c;
      tgt_r  <= tgt_c;
      ins_r  <= ins_c;
    end
    if (out_load) begin
      out_hit_r <= hit_r;
      out_val_r <= hval_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_val_r;

endmodule

// File: hw/rtl/lkv_cell.sv
module lkv_cell import lkv_pkg::*; #(
  parameter int KB    = 32,
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [KB-1:0] key_i,
  input  cell_ctl_t     ctl_i,
  input  logic [KB-1:0] prev_key_i,
  input  value_t        prev_val_i,
  input  logic          prev_valid_i,
  output logic [KB-1:0] key_o,
  output value_t        val_o,
  output logic          valid_o,
  output logic          match_o
);

  localparam logic [IDX_W-1:0] POS = IDX_W'(IDX);

  logic [KB-1:0] key_r;
  value_t        val_r;
  logic          valid_r;
  logic          shift;

  // cells at or below the target position take their neighbor's entry
  assign shift   = ctl_i.upd && (POS <= ctl_i.tgt[IDX_W-1:0]);
  assign match_o = valid_r && (key_r == key_i);
  assign key_o   = key_r;
  assign val_o   = val_r;
  assign valid_o = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= prev_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key_r <= prev_key_i;
      val_r <= prev_val_i;
    end
  end

endmodule

// File: hw/rtl/lkv_checker.sv
module lkv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic [31:0] out_read_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) && $stable(out_read_value))
    else $error("held result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer taken during compare");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_read_value == 32'd0)
    else $error("miss with nonzero value");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hit        (out_hit),
  .out_read_value (out_read_value)
);

// File: tb/sv/tb_lru_key_value_cache.sv
module tb_lru_key_value_cache import lkv_pkg::*;;

  localparam int SLOTS = 16;

  typedef struct packed {
    logic     op;
    value_t   key;
    value_t   wval;
  } request_t;

  typedef struct packed {
    logic   hit;
    value_t data;
  } lookup_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_operation = OP_GET;
  logic signed [31:0] in_key = '0;
  logic signed [31:0] in_write_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_hit;
  logic signed [31:0] out_read_value;
  logic               cfg_we = 1'b0;
  logic [4:0]         cfg_wdata = '0;

  lru_key_value_cache DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_key         (in_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // cache model
  value_t     ent_key [SLOTS];
  value_t     ent_val [SLOTS];
  logic       ent_live [SLOTS];
  int         ent_age [SLOTS];
  logic [4:0] cap_model;

  request_t pending_reqs[$];
  lookup_t  lookup_exp[$];
  logic     in_fire = 1'b0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       errors = 0;
  int       lookups_checked = 0;
  int       hits_seen = 0;
  int       stores_sent = 0;

  function automatic int eff_capacity();
    if (cap_model == 5'd0) return 1;
    if (cap_model > SLOTS) return SLOTS;
    return cap_model;
  endfunction

  task automatic make_newest(input int s);
    int r;
    r = ent_age[s];
    for (int i = 0; i < SLOTS; i++) begin
      if (ent_live[i] && i != s && ent_age[i] < r) ent_age[i]++;
    end
    ent_age[s] = 0;
  endtask

  task automatic cache_access(input request_t req);
    int s;
    int cnt;
    int free_slot;
    int oldest;
    lookup_t res;
    s = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (s < 0 && ent_live[i] && ent_key[i] == req.key) s = i;
    end
    if (req.op == OP_GET) begin
      if (s >= 0) begin
        make_newest(s);
        res.hit = 1'b1;
        res.data = ent_val[s];
      end else begin
        res.hit = 1'b0;
        res.data = '0;
      end
      lookup_exp.push_back(res);
    end else if (s >= 0) begin
      ent_val[s] = req.wval;
      make_newest(s);
    end else begin
      cnt = 0;
      free_slot = -1;
      oldest = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (ent_live[i]) begin
          cnt++;
          if (oldest < 0 || ent_age[i] > ent_age[oldest]) oldest = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (cnt < eff_capacity() && free_slot >= 0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (ent_live[i]) ent_age[i]++;
        end
        ent_live[free_slot] = 1'b1;
        ent_key[free_slot] = req.key;
        ent_val[free_slot] = req.wval;
        ent_age[free_slot] = 0;
      end else if (oldest >= 0) begin
        ent_key[oldest] = req.key;
        ent_val[oldest] = req.wval;
        make_newest(oldest);
      end
    end
  endtask

  // driver
  always @(negedge clk) begin
    request_t req;
    if (rst_n && (!in_valid || in_fire)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req = pending_reqs.pop_front();
        in_operation <= req.op;
        in_key <= req.key;
        in_write_value <= req.wval;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // monitor and predictor
  always @(posedge clk) begin
    lookup_t want;
    if (rst_n) begin
      if (cfg_we) cap_model = cfg_wdata;
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        if (in_operation == OP_SET) stores_sent++;
        cache_access('{op: in_operation, key: in_key, wval: in_write_value});
      end
      if (out_valid && !out_stall) begin
        if (lookup_exp.size() == 0) begin
          $error("unexpected result: hit %0d read_value %0h", out_hit, out_read_value);
          errors++;
        end else begin
          want = lookup_exp.pop_front();
          lookups_checked++;
          if (want.hit) hits_seen++;
          if (out_hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_hit);
            errors++;
          end
          if (out_read_value !== want.data) begin
            $error("read_value: expected %0h, got %0h", want.data, out_read_value);
            errors++;
          end
        end
      end
    end else begin
      in_fire <= 1'b0;
      cap_model = CAP_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        ent_live[i] = 1'b0;
        ent_age[i] = 0;
      end
    end
  end

  task automatic push_req(input logic op, input value_t k, input value_t v);
    pending_reqs.push_back('{op: op, key: k, wval: v});
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid || lookup_exp.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [4:0] cap);
    cfg_wdata <= cap;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1: begin
        send_idle_pct = 87;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 87;
      end
      3: begin
        send_idle_pct = 33;
        recv_stall_pct = 33;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // keys come mostly from a pool a little larger than the capacity
  task automatic queue_random(input int n, input int pool_size);
    value_t key_pool[$];
    logic   op;
    value_t k;
    for (int i = 0; i < pool_size; i++) key_pool.push_back($urandom);
    repeat (n) begin
      op = $urandom_range(1) ? OP_SET : OP_GET;
      if ($urandom_range(9) == 0) k = $urandom;
      else k = key_pool[$urandom_range(pool_size - 1)];
      push_req(op, k, $urandom);
    end
  endtask

  initial begin
    logic [4:0] caps  [6];
    int         modes [6];
    int         eff;
    caps = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd17, 5'd9};
    modes = '{0, 1, 2, 3, 1, 2};
    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // two entries: miss on empty, extremes, eviction order, update in place
    set_capacity(5'd2);
    set_idling(0);
    push_req(OP_GET, 32'h0, 32'h0);
    push_req(OP_SET, 32'h8000_0000, 32'h7fff_ffff);
    push_req(OP_SET, 32'h7fff_ffff, 32'h8000_0000);
    push_req(OP_GET, 32'h8000_0000, 32'h0);
    push_req(OP_SET, 32'hffff_ffff, 32'h0);
    push_req(OP_GET, 32'h7fff_ffff, 32'hffff_ffff);
    push_req(OP_GET, 32'hffff_ffff, 32'h0);
    push_req(OP_SET, 32'h8000_0000, 32'h5a5a_5a5a);
    push_req(OP_GET, 32'h8000_0000, 32'h0);
    push_req(OP_SET, 32'h0, 32'hffff_ffff);
    push_req(OP_GET, 32'hffff_ffff, 32'h0);
    push_req(OP_GET, 32'h0, 32'h7fff_ffff);
    push_req(OP_SET, 32'h0, 32'h0);
    push_req(OP_GET, 32'h0, 32'ha5a5_a5a5);
    push_req(OP_GET, 32'h8000_0000, 32'h0);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      set_capacity(caps[p]);
      set_idling(modes[p]);
      eff = (caps[p] == 5'd0) ? 1 : ((caps[p] > SLOTS) ? SLOTS : caps[p]);
      queue_random(130, eff + 2);
    end
    wait_idle();
    repeat (10) @(negedge clk);

    $display("checked %0d lookups (%0d hits) and sent %0d stores", lookups_checked,
             hits_seen, stores_sent);
    $display("capacities 2,16,3,0,31,17,9 under four idle and stall mixes");
    if (errors == 0) begin
      $display("tb_lru_key_value_cache: done, clean");
    end else begin
      $display("tb_lru_key_value_cache: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("tb_lru_key_value_cache: done, errors");
    $finish;
  end

endmodule

// File: lru_key_value_cache.f
hw/rtl/lkv_pkg.sv
hw/rtl/lkv_cell.sv
hw/rtl/lru_key_value_cache.sv
hw/rtl/lkv_checker.sv
tb/sv/tb_lru_key_value_cache.sv
